>>> hdl/sobel_pkg.sv
// ----------------------------------------------------------------------------
// sobel_pkg: shared constants, types and functions for the Sobel edge block
// Holds field widths, the register map, the root cell type and the gray helper.
// ----------------------------------------------------------------------------
package sobel_pkg;

	localparam int unsigned MAX_WIDTH_DEF = 1024;
	localparam int unsigned MAX_HEIGHT    = 4096;
	localparam int unsigned PIX_W         = 8;
	localparam int unsigned WIDTH_REG_W   = 11;
	localparam int unsigned HEIGHT_REG_W  = 13;
	localparam int unsigned ROW_W         = 12;
	localparam int unsigned SQ_W          = 17;
	localparam int unsigned ROOT_STEPS    = 8;

	localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = WIDTH_REG_W'(640);
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = HEIGHT_REG_W'(480);

	// register byte addresses
	localparam logic [2:0] ADDR_WIDTH  = 3'd0;
	localparam logic [2:0] ADDR_HEIGHT = 3'd4;

	// state handed from one root cell to the next
	typedef struct packed {
		logic        valid;
		logic        last;
		logic        sat;
		logic [15:0] rem;
		logic [7:0]  root;
	} root_cell_t;

	// gray = floor((r+g+b)/3) via multiply by reciprocal: x*683 >> 11 exact for x<=765
	function automatic logic [PIX_W-1:0] gray_of(input logic [9:0] sum);
		logic [19:0] prod;
		prod = 20'(sum) * 20'd683;
		return prod[18:11];
	endfunction

endpackage

>>> hdl/sobel_root_cell.sv
// ----------------------------------------------------------------------------
// sobel_root_cell: one digit step of the integer square root
// Resolves one result bit per advancing cycle and passes partial state on.
// ----------------------------------------------------------------------------
module sobel_root_cell #(
	parameter int unsigned BIT_POS = 7
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  advance,
	input  sobel_pkg::root_cell_t cell_in,
	output sobel_pkg::root_cell_t cell_out
);

	logic [15:0] trial;
	logic [15:0] cand_root_sq;
	logic [7:0]  cand_root;
	logic        take;
	logic        valid_q;
	logic        last_q;
	logic        sat_q;
	logic [15:0] rem_q;
	logic [7:0]  root_q;

	// try setting this bit: (root | b)^2 - root^2 = 2*root*b + b*b
	always_comb begin
		cand_root    = cell_in.root | (8'd1 << BIT_POS);
		cand_root_sq = (16'(cell_in.root) << (BIT_POS + 1)) | (16'd1 << (2 * BIT_POS));
		trial        = cand_root_sq;
		take         = cell_in.rem >= trial;
	end

	// advance the partial root
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= cell_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			last_q <= cell_in.last;
			sat_q  <= cell_in.sat;
			rem_q  <= take ? cell_in.rem - trial : cell_in.rem;
			root_q <= take ? cand_root : cell_in.root;
		end
	end

	assign cell_out = {valid_q, last_q, sat_q, rem_q, root_q};

endmodule

>>> hdl/sobel_window.sv
// ----------------------------------------------------------------------------
// sobel_window: gray conversion, line buffers, 3x3 window and gradient sum
// Produces the squared magnitude of each full window with its frame flag.
// ----------------------------------------------------------------------------
module sobel_window #(
	parameter int unsigned MAX_WIDTH = sobel_pkg::MAX_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  advance,
	input  logic                                  pix_valid,
	input  logic [7:0]                            red,
	input  logic [7:0]                            green,
	input  logic [7:0]                            blue,
	input  logic                                  restart,
	input  logic [sobel_pkg::WIDTH_REG_W-1:0]     image_width,
	input  logic [sobel_pkg::HEIGHT_REG_W-1:0]    image_height,
	output sobel_pkg::root_cell_t                 cell_out
);

	localparam int unsigned COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int unsigned CNT_W = $clog2(MAX_WIDTH + 1);

	logic [7:0] upper_mem [MAX_WIDTH];
	logic [7:0] middle_mem [MAX_WIDTH];

	logic [CNT_W-1:0]             col_q;
	logic [sobel_pkg::ROW_W-1:0]  row_q;
	logic [CNT_W-1:0]             width_used;
	logic [sobel_pkg::HEIGHT_REG_W-1:0] height_used;
	logic [CNT_W-1:0]             x;
	logic [sobel_pkg::HEIGHT_REG_W-1:0] y;
	logic [7:0]                   gray;
	logic [7:0]                   top_s1;
	logic [7:0]                   mid_s1;
	logic [7:0]                   gray_s1;
	logic                         valid_s1;
	logic                         emit_s1;
	logic                         last_s1;
	logic [7:0]                   win_q [6];
	logic signed [11:0]           gx_s2;
	logic signed [11:0]           gy_s2;
	logic                         valid_s2;
	logic                         last_s2;
	logic [21:0]                  gx2_s3;
	logic [21:0]                  gy2_s3;
	logic                         valid_s3;
	logic                         last_s3;
	logic [22:0]                  sq;
	logic signed [11:0]           gx;
	logic signed [11:0]           gy;

	// clamp the configured sizes
	always_comb begin
		if (image_width < 3)
			width_used = CNT_W'(3);
		else if (32'(image_width) > MAX_WIDTH)
			width_used = CNT_W'(MAX_WIDTH);
		else
			width_used = CNT_W'(image_width);
		if (image_height < 3)
			height_used = sobel_pkg::HEIGHT_REG_W'(3);
		else if (32'(image_height) > sobel_pkg::MAX_HEIGHT)
			height_used = sobel_pkg::HEIGHT_REG_W'(sobel_pkg::MAX_HEIGHT);
		else
			height_used = image_height;
		x = (col_q >= width_used) ? '0 : col_q;
		y = (sobel_pkg::HEIGHT_REG_W'(row_q) >= height_used) ? '0
			: sobel_pkg::HEIGHT_REG_W'(row_q);
		gray = sobel_pkg::gray_of(10'(red) + 10'(green) + 10'(blue));
	end

	// advance the pixel position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance && pix_valid) begin
			if (x + 1'b1 >= width_used) begin
				col_q <= '0;
				row_q <= (y + 1'b1 >= height_used) ? '0 : sobel_pkg::ROW_W'(y + 1'b1);
			end else begin
				col_q <= x + 1'b1;
				row_q <= sobel_pkg::ROW_W'(y);
			end
		end
	end

	// line buffers: read old column, write new values
	always_ff @(posedge clk) begin
		if (advance && pix_valid) begin
			top_s1  <= upper_mem[x[COL_W-1:0]];
			mid_s1  <= middle_mem[x[COL_W-1:0]];
			upper_mem[x[COL_W-1:0]]  <= middle_mem[x[COL_W-1:0]];
			middle_mem[x[COL_W-1:0]] <= gray;
			gray_s1 <= gray;
			emit_s1 <= (x >= 2) && (y >= 2);
			last_s1 <= (x == width_used - 1'b1) && (y == height_used - 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			for (int i = 0; i < 6; i++) win_q[i] <= '0;
		end else if (advance) begin
			valid_s1 <= pix_valid;
			valid_s2 <= valid_s1 && emit_s1;
			valid_s3 <= valid_s2;
			// shift the window one column
			if (valid_s1) begin
				win_q[0] <= win_q[3];
				win_q[1] <= win_q[4];
				win_q[2] <= win_q[5];
				win_q[3] <= top_s1;
				win_q[4] <= mid_s1;
				win_q[5] <= gray_s1;
			end
		end
	end

	// gradient sums over the full window
	always_comb begin
		gx = (12'(win_q[0]) + (12'(win_q[1]) << 1) + 12'(win_q[2]))
			- (12'(top_s1) + (12'(mid_s1) << 1) + 12'(gray_s1));
		gy = (12'(win_q[0]) + (12'(win_q[3]) << 1) + 12'(top_s1))
			- (12'(win_q[2]) + (12'(win_q[5]) << 1) + 12'(gray_s1));
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			gx_s2   <= gx;
			gy_s2   <= gy;
			last_s2 <= last_s1;
			gx2_s3  <= 22'(gx_s2 * gx_s2);
			gy2_s3  <= 22'(gy_s2 * gy_s2);
			last_s3 <= last_s2;
		end
	end

	assign sq = 23'(gx2_s3) + 23'(gy2_s3);

	always_comb begin
		cell_out.valid = valid_s3;
		cell_out.last  = last_s3;
		cell_out.sat   = sq >= 23'd65536;
		cell_out.rem   = sq[15:0];
		cell_out.root  = '0;
	end

endmodule

>>> hdl/sobel_edge_magnitude.sv
// ----------------------------------------------------------------------------
// sobel_edge_magnitude: 3x3 Sobel gradient magnitude over an RGB stream
// Gray conversion, line buffers, window, gradient and a chain of root cells.
// ----------------------------------------------------------------------------
// channel  | dir | handshake        | payload
// s_axis   | in  | tvalid/tready    | tdata: red, green, blue
// m_axis   | out | tvalid/tready    | tdata: edge_value, tlast: frame_last
// apb      | in  | psel/penable     | image_width @0, image_height @4
// One pixel per cycle is accepted unless stalled or restarting; each result
// passes three window stages, eight root cells and the output register.
// The whole chain moves together and holds while a result waits at m_axis.
// Reset clears counters, window and valid flags; line buffers are not cleared.
// A write to either register restarts the frame at column zero, row zero.
module sobel_edge_magnitude #(
	parameter int unsigned MAX_WIDTH = sobel_pkg::MAX_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // red[7:0], green[15:8], blue[23:16]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // edge_value[7:0]
	output logic        m_axis_tlast,  // frame_last
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [sobel_pkg::WIDTH_REG_W-1:0]  width_q;
	logic [sobel_pkg::HEIGHT_REG_W-1:0] height_q;
	logic                               wr_en;
	logic                               restart;
	logic                               advance;
	sobel_pkg::root_cell_t              chain [sobel_pkg::ROOT_STEPS+1];
	logic                               out_valid_q;
	logic [7:0]                         out_data_q;
	logic                               out_last_q;
	logic                               tail_valid;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= sobel_pkg::WIDTH_RESET;
			height_q <= sobel_pkg::HEIGHT_RESET;
			restart  <= 1'b0;
		end else begin
			restart <= 1'b0;
			if (wr_en) begin
				unique case (paddr)
					sobel_pkg::ADDR_WIDTH: begin
						width_q <= pwdata[sobel_pkg::WIDTH_REG_W-1:0];
						restart <= 1'b1;
					end
					sobel_pkg::ADDR_HEIGHT: begin
						height_q <= pwdata[sobel_pkg::HEIGHT_REG_W-1:0];
						restart <= 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		unique case (paddr)
			sobel_pkg::ADDR_WIDTH:  prdata = 32'(width_q);
			sobel_pkg::ADDR_HEIGHT: prdata = 32'(height_q);
			default:                prdata = '0;
		endcase
	end

	// move the chain unless the output slot is full and stalled
	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = advance && !restart;
	assign tail_valid    = chain[sobel_pkg::ROOT_STEPS].valid;

	sobel_window #(.MAX_WIDTH(MAX_WIDTH)) u_window (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.pix_valid    (s_axis_tvalid && s_axis_tready),
		.red          (s_axis_tdata[7:0]),
		.green        (s_axis_tdata[15:8]),
		.blue         (s_axis_tdata[23:16]),
		.restart      (restart),
		.image_width  (width_q),
		.image_height (height_q),
		.cell_out     (chain[0])
	);

	for (genvar i = 0; i < sobel_pkg::ROOT_STEPS; i++) begin : g_root
		sobel_root_cell #(.BIT_POS(sobel_pkg::ROOT_STEPS - 1 - i)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.advance  (advance),
			.cell_in  (chain[i]),
			.cell_out (chain[i+1])
		);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= tail_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= chain[sobel_pkg::ROOT_STEPS].sat ? 8'hFF
				: chain[sobel_pkg::ROOT_STEPS].root;
			out_last_q <= chain[sobel_pkg::ROOT_STEPS].last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_axis_tready) |=> (out_valid_q && $stable(out_data_q)))
		else $error("result changed while stalled");
	a_no_take_on_restart: assert property (@(posedge clk) disable iff (!arst_n)
		restart |-> !s_axis_tready)
		else $error("pixel taken during restart");
	a_stall_stops_input: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_axis_tready) |-> !s_axis_tready)
		else $error("pixel taken while chain stalled");

endmodule

>>> tb/tb_sobel_edge_magnitude.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sobel_edge_magnitude: self-checking bench for the Sobel edge block
// Streams RGB frames of many sizes through the block, predicts each gradient
// magnitude and frame-end flag, and compares every result in order.
// ----------------------------------------------------------------------------
module tb_sobel_edge_magnitude;

	localparam int CYCLE_LIMIT = 600000;
	localparam int LINE_DEPTH  = int'(sobel_pkg::MAX_WIDTH_DEF);
	localparam int DRAIN_WAIT  = 30;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;  // red[7:0], green[15:8], blue[23:16]
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;  // edge_value[7:0]
	logic        m_axis_tlast;  // frame_last
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	sobel_edge_magnitude dut (.*);

	typedef struct packed {
		logic [7:0] edge_value;
		logic       frame_last;
	} edge_result_t;

	typedef struct {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		bit         typed;
		logic [7:0] typed_edge;
		logic       typed_last;
	} pixel_row_t;

	edge_result_t pending_edges[$];
	int           errors = 0;
	int           cycles = 0;
	bit           quiet;

	// model of the block's state
	logic [7:0]                             upper_gray[LINE_DEPTH];
	logic [7:0]                             middle_gray[LINE_DEPTH];
	logic [7:0]                             win_gray[6];
	logic [sobel_pkg::WIDTH_REG_W-1:0]      width_reg;
	logic [sobel_pkg::HEIGHT_REG_W-1:0]     height_reg;
	int                                     col_pos;
	int                                     row_pos;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// cycle watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic int isqrt_floor(input int unsigned v);
		int r;
		r = 0;
		while ((r + 1) * (r + 1) <= v)
			r++;
		return r;
	endfunction

	// advance the model by one pixel; returns 1 if a result is due
	function automatic bit predict_edge(input logic [7:0] red, input logic [7:0] green,
			input logic [7:0] blue, output edge_result_t res);
		int w, h, gray, top, mid, gx, gy;
		int unsigned sq;
		bit due;
		w = (width_reg < 3) ? 3 : (width_reg > LINE_DEPTH) ? LINE_DEPTH : width_reg;
		h = (height_reg < 3) ? 3
			: (height_reg > sobel_pkg::MAX_HEIGHT) ? sobel_pkg::MAX_HEIGHT : height_reg;
		if (col_pos >= w) col_pos = 0;
		if (row_pos >= h) row_pos = 0;
		gray = (int'(red) + int'(green) + int'(blue)) / 3;
		top = upper_gray[col_pos];
		mid = middle_gray[col_pos];
		due = (col_pos >= 2 && row_pos >= 2);
		res = '0;
		if (due) begin
			gx = (win_gray[0] + 2 * win_gray[1] + win_gray[2]) - (top + 2 * mid + gray);
			gy = (win_gray[0] + 2 * win_gray[3] + top) - (win_gray[2] + 2 * win_gray[5] + gray);
			sq = gx * gx + gy * gy;
			res.edge_value = (sq >= 65536) ? 8'd255 : 8'(isqrt_floor(sq));
			res.frame_last = (col_pos == w - 1 && row_pos == h - 1);
		end
		win_gray[0] = win_gray[3];
		win_gray[1] = win_gray[4];
		win_gray[2] = win_gray[5];
		win_gray[3] = top[7:0];
		win_gray[4] = mid[7:0];
		win_gray[5] = gray[7:0];
		upper_gray[col_pos] = mid[7:0];
		middle_gray[col_pos] = gray[7:0];
		col_pos++;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
			if (row_pos >= h) row_pos = 0;
		end
		return due;
	endfunction

	// occasional source-side gap with tvalid low, skipped while quiet
	task automatic source_gap();
		if (!quiet && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	// send one pixel; the typed result, if any, replaces the predicted one
	task automatic send_pixel(input pixel_row_t px);
		edge_result_t res;
		source_gap();
		if (predict_edge(px.red, px.green, px.blue, res)) begin
			if (px.typed) begin
				res.edge_value = px.typed_edge;
				res.frame_last = px.typed_last;
			end
			pending_edges.push_back(res);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {px.blue, px.green, px.red};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic send_rgb(input logic [7:0] red, input logic [7:0] green,
			input logic [7:0] blue);
		pixel_row_t px;
		px = '{red, green, blue, 1'b0, 8'd0, 1'b0};
		send_pixel(px);
	endtask

	// let the block drain, then write one register
	task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_edges.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (addr == sobel_pkg::ADDR_WIDTH)
			width_reg = value[sobel_pkg::WIDTH_REG_W-1:0];
		else
			height_reg = value[sobel_pkg::HEIGHT_REG_W-1:0];
		col_pos = 0;
		row_pos = 0;
	endtask

	task automatic set_size(input int w, input int h);
		write_reg(sobel_pkg::ADDR_WIDTH, 32'(w));
		write_reg(sobel_pkg::ADDR_HEIGHT, 32'(h));
	endtask

	// random pixel in one of several flavors
	task automatic send_random_pixel(input int flavor);
		logic [7:0] v;
		case (flavor)
			0: begin
				send_rgb(8'($urandom), 8'($urandom), 8'($urandom));
			end
			1: begin
				v = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				send_rgb(v, v, v);
			end
			default: begin
				v = 8'($urandom_range(100, 140));
				send_rgb(v + 8'($urandom_range(0, 3)), v, v - 8'($urandom_range(0, 3)));
			end
		endcase
	endtask

	task automatic send_frame(input int pixels);
		int flavor;
		flavor = $urandom_range(0, 3);
		for (int i = 0; i < pixels; i++)
			send_random_pixel(flavor);
	endtask

	// random ready stalls in bursts
	int stall_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_left    <= 0;
		end else if (quiet) begin
			m_axis_tready <= 1'b1;
		end else if (stall_left > 0) begin
			m_axis_tready <= 1'b0;
			stall_left    <= stall_left - 1;
		end else if ($urandom_range(0, 5) == 0) begin
			m_axis_tready <= 1'b0;
			stall_left    <= $urandom_range(0, 4);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// compare each result with the oldest expectation
	always @(posedge clk) begin
		edge_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_edges.size() == 0) begin
				$display("%0t: unexpected result edge=%0d last=%0b", $realtime,
					m_axis_tdata, m_axis_tlast);
				errors++;
			end else begin
				want = pending_edges.pop_front();
				if (m_axis_tdata !== want.edge_value) begin
					$display("%0t: edge_value expected %0d actual %0d", $realtime,
						want.edge_value, m_axis_tdata);
					errors++;
				end
				if (m_axis_tlast !== want.frame_last) begin
					$display("%0t: frame_last expected %0b actual %0b", $realtime,
						want.frame_last, m_axis_tlast);
					errors++;
				end
			end
		end
	end

	pixel_row_t directed_rows[$];

	initial begin
		int items;
		int w, h, n;
		quiet = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		width_reg = sobel_pkg::WIDTH_RESET;
		height_reg = sobel_pkg::HEIGHT_RESET;
		col_pos = 0;
		row_pos = 0;
		for (int i = 0; i < LINE_DEPTH; i++) begin
			upper_gray[i] = '0;
			middle_gray[i] = '0;
		end
		for (int i = 0; i < 6; i++) win_gray[i] = '0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// after reset: a few pixels in the first row, no results
		for (int i = 0; i < 16; i++) send_random_pixel(0);

		// 3x3 frames; left column bright saturates, flat frame gives zero
		set_size(3, 3);
		directed_rows = '{
			'{8'hFF, 8'hFF, 8'hFF, 0, 0, 0}, '{8'h00, 8'h00, 8'h00, 0, 0, 0},
			'{8'h00, 8'h00, 8'h00, 0, 0, 0},
			'{8'hFF, 8'hFF, 8'hFF, 0, 0, 0}, '{8'h00, 8'h00, 8'h00, 0, 0, 0},
			'{8'h00, 8'h00, 8'h00, 0, 0, 0},
			'{8'hFF, 8'hFF, 8'hFF, 0, 0, 0}, '{8'h00, 8'h00, 8'h00, 0, 0, 0},
			'{8'h00, 8'h00, 8'h00, 1, 8'd255, 1'b1},
			'{8'h00, 8'h00, 8'h00, 0, 0, 0}, '{8'h00, 8'h00, 8'h00, 0, 0, 0},
			'{8'h00, 8'h00, 8'h00, 0, 0, 0}, '{8'h00, 8'h00, 8'h00, 0, 0, 0},
			'{8'h00, 8'h00, 8'h00, 0, 0, 0}, '{8'h00, 8'h00, 8'h00, 0, 0, 0},
			'{8'h00, 8'h00, 8'h00, 0, 0, 0}, '{8'h00, 8'h00, 8'h00, 0, 0, 0},
			'{8'h00, 8'h00, 8'h00, 1, 8'd0, 1'b1},
			// gray rounding and a mild gradient
			'{8'hFF, 8'hFF, 8'hFE, 0, 0, 0}, '{8'h01, 8'h00, 8'h00, 0, 0, 0},
			'{8'h02, 8'h02, 8'h01, 0, 0, 0},
			'{8'h10, 8'h20, 8'h30, 0, 0, 0}, '{8'h80, 8'h7F, 8'h81, 0, 0, 0},
			'{8'hAA, 8'h55, 8'h00, 0, 0, 0},
			'{8'h00, 8'hFF, 8'h00, 0, 0, 0}, '{8'h00, 8'h00, 8'hFF, 0, 0, 0}
		};
		foreach (directed_rows[i]) send_pixel(directed_rows[i]);

		// out-of-range sizes clamp; both registers see all bits set
		set_size(2047, 0);
		send_frame(40);
		set_size(0, 8191);
		send_frame(3 * 12);
		set_size(3, 8191);
		send_frame(30);
		set_size(1024, 3);
		send_frame(60);

		// random frames of small sizes, some cut short by a register write
		items = 0;
		while (items < 1100) begin
			quiet = (items > 900);
			w = $urandom_range(0, 9) == 0 ? $urandom_range(13, 60) : $urandom_range(3, 12);
			h = $urandom_range(3, 7);
			if ($urandom_range(0, 1)) write_reg(sobel_pkg::ADDR_WIDTH, 32'(w));
			else set_size(w, h);
			w = (width_reg < 3) ? 3 : width_reg;
			h = (height_reg < 3) ? 3 : height_reg;
			for (int f = $urandom_range(1, 2); f > 0; f--) begin
				if (h > 8) h = 8;
				n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, w * h) : w * h;
				send_frame(n);
				items += n;
			end
		end

		s_axis_tvalid <= 1'b0;
		while (pending_edges.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

>>> sim.f
hdl/sobel_pkg.sv
hdl/sobel_root_cell.sv
hdl/sobel_window.sv
hdl/sobel_edge_magnitude.sv
tb/tb_sobel_edge_magnitude.sv
